@@ design/bclt_pkg.sv @@
// Package for the block chain link table: field widths, parameter defaults,
// request kind and status codes, and the sequencer state type.
// No dependencies.
package bclt_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 1024;
  localparam int unsigned MAX_CHAIN_DEF  = 64;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned HEAD_W   = 10;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned FREED_W  = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USABLE_W = 11;

  localparam logic [USABLE_W-1:0] USABLE_RESET = 11'd1024;

  localparam logic [KIND_W-1:0] KIND_FREE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REWRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FOLLOW  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_HEAD    = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_FOLLOW_CHK,
    S_WALK_CHK,
    S_HEAD_WR,
    S_SCAN,
    S_LINK_WR1,
    S_LINK_WR2,
    S_REPORT
  } state_t;

endpackage

@@ design/bclt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bclt_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/block_chain_link_table_top.sv @@
// Block chain link table: a file-allocation style link table in one RAM, run by a small
// sequencer around a single read/compare path. After reset a clearing pass writes the
// table (entry 0 end, all others free); no request is taken meanwhile. One request at a
// time: a link read is a RAM read, then a check; freeing a chain takes, per chain entry,
// a RAM read, then check and write back; a rewrite adds an upward free search over the
// table entries and, per block linked, a search start, a link write and an end-mark
// write. The single RAM port pair sets these steps. Results leave through an output
// register, so a stalled consumer holds the sequencer only when a new result is ready.
module block_chain_link_table_top #(
  parameter int unsigned NUM_BLOCKS = bclt_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned MAX_CHAIN  = bclt_pkg::MAX_CHAIN_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bclt_pkg::USABLE_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bclt_pkg::KIND_W-1:0]    kind,
  input  logic [bclt_pkg::HEAD_W-1:0]    head_block,
  input  logic [bclt_pkg::COUNT_W-1:0]   block_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bclt_pkg::INDEX_W-1:0]   block_index,
  output logic [bclt_pkg::FREED_W-1:0]   freed_count,
  output logic                           at_end,
  output logic [bclt_pkg::STATUS_W-1:0]  status,
  output logic                           last
);
  import bclt_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned ENT_W = IDX_W + 2;
  // entry = {end flag, free flag, next index}
  localparam logic [ENT_W-1:0] ENT_FREE = ENT_W'(1) << IDX_W;
  localparam logic [ENT_W-1:0] ENT_END  = ENT_W'(2) << IDX_W;

  state_t state, state_next;

  logic [USABLE_W-1:0] usable_blocks;
  logic [USABLE_W-1:0] lim, walk_lim;

  logic [KIND_W-1:0]  op_kind;
  logic [IDX_W-1:0]   head, cur, scan_chk;
  logic [IDX_W:0]     scan_addr;
  logic               scan_pend;
  logic [COUNT_W-1:0] want, k;
  logic [FREED_W-1:0] n;
  logic [INDEX_W-1:0] res_idx;
  logic               res_end;
  status_t            res_st;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic             rd_free, rd_end;
  logic [IDX_W-1:0] rd_idx;
  logic             in_take, head_ok, out_free, out_load, out_is_last;
  logic             walk_free_ok, walk_fin;
  status_t          walk_st;
  logic             scan_hit, scan_miss;

  bclt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_free = ram_rdata[IDX_W];
  assign rd_end  = ram_rdata[IDX_W+1];
  assign rd_idx  = ram_rdata[IDX_W-1:0];

  assign lim      = (32'(usable_blocks) < NUM_BLOCKS) ? usable_blocks : USABLE_W'(NUM_BLOCKS);
  assign walk_lim = (lim == '0) ? USABLE_W'(1) : lim;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign head_ok  = 32'(head_block) < NUM_BLOCKS;
  assign out_free = !out_valid || !out_stall;

  // walk step: free the current entry unless it is already free or the limit is hit
  assign walk_free_ok = !rd_free && (32'(n) < 32'(walk_lim));
  assign walk_fin     = !walk_free_ok || rd_end;
  always_comb begin
    if (rd_free) begin
      walk_st = (n == '0 && op_kind == KIND_REWRITE) ? ST_OK : ST_BAD;
    end else if (!walk_free_ok) begin
      walk_st = ST_BAD;
    end else begin
      walk_st = ST_OK;
    end
  end

  // rdata belongs to scan_chk, read in the cycle before
  assign scan_hit  = scan_pend && rd_free;
  assign scan_miss = !scan_hit && (32'(scan_addr) >= 32'(lim));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (cur == IDX_W'(NUM_BLOCKS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_take && kind != KIND_NOP) begin
          state_next = head_ok ? S_READ : S_REPORT;
        end
      end
      S_READ: begin
        state_next = (op_kind == KIND_FOLLOW) ? S_FOLLOW_CHK : S_WALK_CHK;
      end
      S_FOLLOW_CHK: state_next = S_REPORT;
      S_WALK_CHK: begin
        if (walk_fin) begin
          if (op_kind == KIND_REWRITE && walk_st == ST_OK && want != '0) begin
            state_next = S_HEAD_WR;
          end else begin
            state_next = S_REPORT;
          end
        end else begin
          state_next = S_READ;
        end
      end
      S_HEAD_WR: state_next = (want == COUNT_W'(1)) ? S_REPORT : S_SCAN;
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_LINK_WR1;
        end else if (scan_miss) begin
          state_next = S_REPORT;
        end
      end
      S_LINK_WR1: begin
        if (out_free) state_next = S_LINK_WR2;
      end
      S_LINK_WR2: begin
        state_next = ((k + COUNT_W'(1)) == want) ? S_REPORT : S_SCAN;
      end
      S_REPORT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM control and result load
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cur;
    ram_wdata   = ENT_FREE;
    ram_raddr   = cur;
    out_load    = 1'b0;
    out_is_last = 1'b1;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = (cur == '0) ? ENT_END : ENT_FREE;
      end
      S_WALK_CHK: ram_we = walk_free_ok;
      S_HEAD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = head;
        ram_wdata = ENT_END;
      end
      S_SCAN: ram_raddr = scan_addr[IDX_W-1:0];
      S_LINK_WR1: begin
        ram_we      = out_free;
        ram_wdata   = {2'b00, scan_chk};
        out_load    = out_free;
        out_is_last = 1'b0;
      end
      S_LINK_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = scan_chk;
        ram_wdata = ENT_END;
      end
      S_REPORT: out_load = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cur           <= '0;
      out_valid     <= 1'b0;
      usable_blocks <= USABLE_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) usable_blocks <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: cur <= cur + IDX_W'(1);
        S_IDLE: begin
          if (in_take) cur <= IDX_W'(head_block);
        end
        S_WALK_CHK: begin
          if (!walk_fin) cur <= rd_idx;
        end
        S_HEAD_WR:  cur <= head;
        S_LINK_WR2: cur <= scan_chk;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          op_kind <= kind;
          head    <= IDX_W'(head_block);
          n       <= '0;
          want    <= (32'(block_count) > MAX_CHAIN) ? COUNT_W'(MAX_CHAIN) : block_count;
          res_idx <= '0;
          res_end <= 1'b0;
          res_st  <= ST_HEAD;
        end
      end
      S_FOLLOW_CHK: begin
        res_idx <= (rd_end || rd_free) ? '0 : INDEX_W'(rd_idx);
        res_end <= rd_end;
        res_st  <= rd_free ? ST_BAD : ST_OK;
      end
      S_WALK_CHK: begin
        if (walk_free_ok) n <= n + FREED_W'(1);
        res_st <= walk_st;
      end
      S_HEAD_WR: begin
        k         <= COUNT_W'(1);
        scan_addr <= {1'b0, head} + (IDX_W + 1)'(1);
        scan_pend <= 1'b0;
        res_idx   <= INDEX_W'(head);
        res_st    <= ST_OK;
      end
      S_SCAN: begin
        if (!scan_hit) begin
          if (scan_miss) begin
            res_idx <= INDEX_W'(cur);
            res_st  <= ST_NOSPACE;
          end else begin
            scan_chk  <= scan_addr[IDX_W-1:0];
            scan_pend <= 1'b1;
            scan_addr <= scan_addr + (IDX_W + 1)'(1);
          end
        end
      end
      S_LINK_WR2: begin
        k         <= k + COUNT_W'(1);
        scan_addr <= {1'b0, scan_chk} + (IDX_W + 1)'(1);
        scan_pend <= 1'b0;
        res_idx   <= INDEX_W'(scan_chk);
        res_st    <= ST_OK;
      end
      default: ;
    endcase

    if (out_load) begin
      freed_count <= n;
      last        <= out_is_last;
      if (out_is_last) begin
        block_index <= res_idx;
        at_end      <= res_end;
        status      <= res_st;
      end else begin
        block_index <= INDEX_W'(cur);
        at_end      <= 1'b0;
        status      <= ST_OK;
      end
    end
  end

  // no result can come out of the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result valid during clearing pass");

  // only the final result of a request may carry a non-ok status
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_OK)
    else $error("intermediate result with error status");

  // an end-marker link read reports index 0 and closes the request
  a_end_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_end |-> block_index == '0 && last)
    else $error("end marker result malformed");

  // the free search never runs once the wanted chain length is reached
  a_chain_len: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> k < want)
    else $error("chain longer than requested");

endmodule

@@ sim/tb_block_chain_link_table_top.sv @@
// Testbench for block_chain_link_table_top: a directed table, then random requests in
// phases of different usable_blocks, checked against a link-table predictor kept here.
// Depends on bclt_pkg and the design sources only.
module tb_block_chain_link_table_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bclt_pkg::*;

  localparam int unsigned TABLE_SIZE    = NUM_BLOCKS_DEF;
  localparam int unsigned CHAIN_CAP     = MAX_CHAIN_DEF;
  localparam logic [11:0] LINK_END      = 12'hFFF;
  localparam logic [11:0] LINK_FREE     = 12'hFFE;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned PHASE_ITEMS   = 46;

  typedef struct packed {
    logic [INDEX_W-1:0] blk;
    logic [FREED_W-1:0] freed;
    logic               at_end;
    status_t            st;
    logic               last;
  } link_result_t;

  typedef struct packed {
    logic                set_usable;
    logic [KIND_W-1:0]   kind;
    logic [HEAD_W-1:0]   head;
    logic [COUNT_W-1:0]  count;
    logic [USABLE_W-1:0] usable;
    logic                typed;
    link_result_t        want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [USABLE_W-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = '0;
  logic [HEAD_W-1:0]   head_block = '0;
  logic [COUNT_W-1:0]  block_count = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [INDEX_W-1:0]  block_index;
  logic [FREED_W-1:0]  freed_count;
  logic                at_end;
  logic [STATUS_W-1:0] status;
  logic                last;

  block_chain_link_table_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .head_block (head_block),
    .block_count(block_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .block_index(block_index),
    .freed_count(freed_count),
    .at_end     (at_end),
    .status     (status),
    .last       (last)
  );

  // local copy of the link table and the usable_blocks register
  logic [11:0]         link_copy [TABLE_SIZE];
  logic [USABLE_W-1:0] usable_copy;
  link_result_t        due_results [$];
  logic [HEAD_W-1:0]   live_heads [$];
  int unsigned         mismatches = 0;
  int unsigned         cycle_count = 0;
  bit                  calm = 1'b0;

  // Directed part. Rows with typed set carry a single result read off by hand.
  plan_row_t plan [24] = '{
    '{1'b0, KIND_FOLLOW,  10'd0,    7'd0,   11'd0, 1'b1, '{10'd0,    11'd0, 1'b1, ST_OK, 1'b1}},
    '{1'b0, KIND_FOLLOW,  10'd1023, 7'd127, 11'd0, 1'b1, '{10'd0,    11'd0, 1'b0, ST_BAD, 1'b1}},
    '{1'b0, KIND_FREE,    10'd5,    7'd0,   11'd0, 1'b1, '{10'd0,    11'd0, 1'b0, ST_BAD, 1'b1}},
    '{1'b0, KIND_NOP,     10'd1023, 7'd127, 11'd0, 1'b0, '0},
    '{1'b0, KIND_REWRITE, 10'd0,    7'd0,   11'd0, 1'b1, '{10'd0,    11'd1, 1'b0, ST_OK, 1'b1}},
    '{1'b0, KIND_FOLLOW,  10'd0,    7'd0,   11'd0, 1'b1, '{10'd0,    11'd0, 1'b0, ST_BAD, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd0,    7'd1,   11'd0, 1'b1, '{10'd0,    11'd0, 1'b0, ST_OK, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd1023, 7'd3,   11'd0, 1'b1,
      '{10'd1023, 11'd0, 1'b0, ST_NOSPACE, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd10,   7'd64,  11'd0, 1'b0, '0},
    '{1'b0, KIND_REWRITE, 10'd20,   7'd127, 11'd0, 1'b0, '0},
    '{1'b0, KIND_FOLLOW,  10'd20,   7'd0,   11'd0, 1'b0, '0},
    '{1'b0, KIND_FOLLOW,  10'd83,   7'd0,   11'd0, 1'b1, '{10'd0,    11'd0, 1'b1, ST_OK, 1'b1}},
    '{1'b0, KIND_FREE,    10'd10,   7'd0,   11'd0, 1'b0, '0},
    '{1'b0, KIND_FREE,    10'd10,   7'd0,   11'd0, 1'b1, '{10'd0,    11'd0, 1'b0, ST_BAD, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd100,  7'd4,   11'd0, 1'b0, '0},
    '{1'b0, KIND_REWRITE, 10'd200,  7'd3,   11'd0, 1'b0, '0},
    '{1'b0, KIND_FREE,    10'd201,  7'd0,   11'd0, 1'b1, '{10'd0,    11'd2, 1'b0, ST_OK, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd200,  7'd5,   11'd0, 1'b1, '{10'd0,    11'd1, 1'b0, ST_BAD, 1'b1}},
    '{1'b1, KIND_NOP,     10'd0,    7'd0,   11'd1, 1'b0, '0},
    '{1'b0, KIND_FREE,    10'd100,  7'd0,   11'd0, 1'b1, '{10'd0,    11'd1, 1'b0, ST_BAD, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd101,  7'd1,   11'd0, 1'b1, '{10'd0,    11'd1, 1'b0, ST_BAD, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd5,    7'd3,   11'd0, 1'b1,
      '{10'd5,    11'd0, 1'b0, ST_NOSPACE, 1'b1}},
    '{1'b0, KIND_REWRITE, 10'd0,    7'd2,   11'd0, 1'b1,
      '{10'd0,    11'd1, 1'b0, ST_NOSPACE, 1'b1}},
    '{1'b1, KIND_NOP,     10'd0,    7'd0,   11'd1024, 1'b0, '0}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_limit();
    return (usable_copy < TABLE_SIZE) ? int'(usable_copy) : TABLE_SIZE;
  endfunction

  // Frees the chain from head; a free head is an empty chain only if head_may_be_free.
  function automatic status_t free_chain_walk(input logic [HEAD_W-1:0] head,
                                              input logic head_may_be_free,
                                              output logic [FREED_W-1:0] freed);
    int unsigned cur;
    int unsigned n;
    int unsigned lim;
    logic [11:0] e;
    cur = 32'(head);
    n = 0;
    lim = active_limit();
    if (lim == 0) lim = 1;
    forever begin
      e = link_copy[cur];
      if (e == LINK_FREE) begin
        freed = FREED_W'(n);
        return (n == 0 && head_may_be_free) ? ST_OK : ST_BAD;
      end
      if (n >= lim) begin
        freed = FREED_W'(n);
        return ST_BAD;
      end
      link_copy[cur] = LINK_FREE;
      n++;
      if (e == LINK_END) break;
      cur = 32'(e);
    end
    freed = FREED_W'(n);
    return ST_OK;
  endfunction

  function automatic void run_link_request(input logic [KIND_W-1:0] k,
                                           input logic [HEAD_W-1:0] h,
                                           input logic [COUNT_W-1:0] c);
    link_result_t r;
    link_result_t chain_out [CHAIN_CAP];
    status_t      st;
    logic [FREED_W-1:0] freed;
    logic [11:0]  e;
    int unsigned  want;
    int unsigned  lim;
    int unsigned  cur;
    int unsigned  found;
    int unsigned  n;
    r = '0;
    case (k)
      KIND_FOLLOW: begin
        e = link_copy[h];
        if (e == LINK_END) r.at_end = 1'b1;
        else if (e == LINK_FREE) r.st = ST_BAD;
        else r.blk = e[INDEX_W-1:0];
        r.last = 1'b1;
        due_results.push_back(r);
      end
      KIND_FREE: begin
        r.st = free_chain_walk(h, 1'b0, freed);
        r.freed = freed;
        r.last = 1'b1;
        due_results.push_back(r);
      end
      KIND_REWRITE: begin
        st = free_chain_walk(h, 1'b1, freed);
        r.freed = freed;
        want = (32'(c) > CHAIN_CAP) ? CHAIN_CAP : 32'(c);
        if (st != ST_OK || want == 0) begin
          r.st = st;
          r.last = 1'b1;
          due_results.push_back(r);
        end else begin
          lim = active_limit();
          cur = 32'(h);
          link_copy[cur] = LINK_END;
          r.blk = h;
          chain_out[0] = r;
          n = 1;
          while (n < want) begin
            found = TABLE_SIZE;
            for (int unsigned i = cur; i < lim; i++) begin
              if (link_copy[i] == LINK_FREE) begin
                found = i;
                break;
              end
            end
            if (found == TABLE_SIZE) begin
              st = ST_NOSPACE;
              break;
            end
            link_copy[cur] = 12'(found);
            link_copy[found] = LINK_END;
            cur = found;
            r.blk = INDEX_W'(found);
            chain_out[n] = r;
            n++;
          end
          chain_out[n-1].st = st;
          chain_out[n-1].last = 1'b1;
          for (int unsigned j = 0; j < n; j++) due_results.push_back(chain_out[j]);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic issue_request(input logic [KIND_W-1:0] k, input logic [HEAD_W-1:0] h,
                               input logic [COUNT_W-1:0] c, input logic typed,
                               input link_result_t want);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    head_block  <= h;
    block_count <= c;
    do @(posedge clk); while (in_stall);
    run_link_request(k, h, c);
    if (typed) due_results[due_results.size()-1] = want;
  endtask

  // register writes only once the block has gone quiet
  task automatic write_usable(input logic [USABLE_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    usable_copy = v;
  endtask

  task automatic flag_field(input string field, input logic [15:0] want_v,
                            input logic [15:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk) begin : check_results
    link_result_t w;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no request pending, expected none, got index %0d status %0d",
                 $time, block_index, status);
      end else begin
        w = due_results.pop_front();
        flag_field("block_index", 16'(w.blk), 16'(block_index));
        flag_field("freed_count", 16'(w.freed), 16'(freed_count));
        flag_field("at_end", 16'(w.at_end), 16'(at_end));
        flag_field("status", 16'(w.st), 16'(status));
        flag_field("last", 16'(w.last), 16'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KIND_W-1:0]   k;
    logic [HEAD_W-1:0]   h;
    logic [COUNT_W-1:0]  c;
    logic [USABLE_W-1:0] phase_usable [6];
    int unsigned         r;
    int unsigned         sel;
    int unsigned         pick;
    int unsigned         span;
    int unsigned         sent;
    for (int unsigned i = 0; i < TABLE_SIZE; i++) link_copy[i] = LINK_FREE;
    link_copy[0] = LINK_END;
    usable_copy = USABLE_RESET;
    phase_usable = '{11'd1024, 11'd48, 11'd1024, 11'd1, 11'd300, 11'd1024};
    phase_usable[4] = USABLE_W'($urandom_range(2, 1023));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[j]) begin
      if (plan[j].set_usable) write_usable(plan[j].usable);
      else issue_request(plan[j].kind, plan[j].head, plan[j].count, plan[j].typed, plan[j].want);
    end

    for (int unsigned p = 0; p < 6; p++) begin
      write_usable(phase_usable[p]);
      calm = (p == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        span = active_limit() + 8;
        if (span > TABLE_SIZE) span = TABLE_SIZE;
        r = $urandom_range(0, 99);
        if (r < 30) k = KIND_FREE;
        else if (r < 68) k = KIND_REWRITE;
        else if (r < 95) k = KIND_FOLLOW;
        else k = KIND_NOP;
        // mostly real chain heads so frees and rewrites walk live chains
        sel = $urandom_range(0, 99);
        if (sel < 60 && live_heads.size() != 0) begin
          pick = $urandom_range(0, live_heads.size() - 1);
          h = live_heads[pick];
          if (k != KIND_FOLLOW) live_heads.delete(pick);
        end else if (sel < 90) begin
          h = HEAD_W'($urandom_range(0, span - 1));
        end else begin
          h = HEAD_W'($urandom());
        end
        r = $urandom_range(0, 99);
        if (r < 8) c = '0;
        else if (r < 16) c = COUNT_W'($urandom_range(65, 127));
        else if (r < 26) c = COUNT_W'($urandom_range(17, 64));
        else c = COUNT_W'($urandom_range(1, 16));
        issue_request(k, h, c, 1'b0, '0);
        if (k == KIND_REWRITE && link_copy[h] != LINK_FREE) begin
          live_heads.push_back(h);
          if (live_heads.size() > 24) void'(live_heads.pop_front());
        end
        if (k != KIND_NOP) sent++;
      end
      calm = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
